FILE: rtl/mbq_pkg.sv
// mbq_pkg: shared types and constants for the multichannel biquad filter
// words on the stream channels, history entry layout, register indexes
// no dependencies
package mbq_pkg;

    localparam int DATA_W = 32;
    localparam int ACC_W  = 64;
    localparam int FRAC_W = 5;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_in;
        logic                     channel;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_out;
        logic                     overflow;
    } t_out_word;

    // per-channel history, one memory word
    typedef struct packed {
        logic signed [DATA_W-1:0] x1;
        logic signed [DATA_W-1:0] x2;
        logic signed [DATA_W-1:0] y1;
        logic signed [DATA_W-1:0] y2;
    } t_hist;

    localparam int HIST_W = $bits(t_hist);

    typedef enum logic [2:0] {
        REG_COEF_B0   = 3'd0,
        REG_COEF_B1   = 3'd1,
        REG_COEF_B2   = 3'd2,
        REG_COEF_A1   = 3'd3,
        REG_COEF_A2   = 3'd4,
        REG_FRAC_BITS = 3'd5
    } t_reg_idx;

    localparam int PADDR_W = 5;

    localparam logic signed [DATA_W-1:0] COEF_B0_RST   = 32'sh4000_0000;
    localparam logic [FRAC_W-1:0]        FRAC_BITS_RST = 5'd30;

    function automatic logic signed [ACC_W-1:0] mul32(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [ACC_W-1:0] ea;
        logic signed [ACC_W-1:0] eb;
        ea = ACC_W'(a);
        eb = ACC_W'(b);
        return ea * eb;
    endfunction

endpackage

FILE: rtl/mbq_stream_if.sv
// mbq_stream_if: valid/ready stream channel carrying one word of type T
// no dependencies; payload types come from mbq_pkg at instantiation
interface mbq_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/multichannel_biquad_df1_fixed_unit.sv
// multichannel_biquad_df1_fixed_unit: direct form I biquad over interleaved channels
// uses mbq_pkg, mbq_stream_if and mbq_ram (per-channel history memory)
//
//   port    dir  word        fields
//   i_in    in   t_in_word   sample_in, channel
//   o_out   out  t_out_word  sample_out, overflow
//   apb     in   32 bits     coef_b0..coef_a2, frac_bits at 4*index
//
// a word goes from accept to o_out.valid through ram read, multiply, partial sums,
// accumulate, shift into the output register.
// a word waits while a word of its channel is in stages 1 to 4 (y1/y2 feedback through
// the history memory read-modify-write), so a channel cannot take a new word before
// its previous word has written its history back; other channels may proceed.
// reset clears valid bits of the history entries, no clearing pass.
// a stalled o_out holds every stage and drops i_in.ready.
module multichannel_biquad_df1_fixed_unit #(
    parameter int NUM_CHANNELS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mbq_stream_if.sink                        i_in,
    mbq_stream_if.source                      o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbq_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // configuration registers
    logic signed [mbq_pkg::DATA_W-1:0] r_coef_b0;
    logic signed [mbq_pkg::DATA_W-1:0] r_coef_b1;
    logic signed [mbq_pkg::DATA_W-1:0] r_coef_b2;
    logic signed [mbq_pkg::DATA_W-1:0] r_coef_a1;
    logic signed [mbq_pkg::DATA_W-1:0] r_coef_a2;
    logic [mbq_pkg::FRAC_W-1:0]        r_frac_bits;

    mbq_pkg::t_reg_idx w_reg_idx;
    logic              w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = mbq_pkg::t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0   <= mbq_pkg::COEF_B0_RST;
            r_coef_b1   <= '0;
            r_coef_b2   <= '0;
            r_coef_a1   <= '0;
            r_coef_a2   <= '0;
            r_frac_bits <= mbq_pkg::FRAC_BITS_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                mbq_pkg::REG_COEF_B0:   r_coef_b0   <= pwdata;
                mbq_pkg::REG_COEF_B1:   r_coef_b1   <= pwdata;
                mbq_pkg::REG_COEF_B2:   r_coef_b2   <= pwdata;
                mbq_pkg::REG_COEF_A1:   r_coef_a1   <= pwdata;
                mbq_pkg::REG_COEF_A2:   r_coef_a2   <= pwdata;
                mbq_pkg::REG_FRAC_BITS: r_frac_bits <= pwdata[mbq_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            mbq_pkg::REG_COEF_B0:   prdata = r_coef_b0;
            mbq_pkg::REG_COEF_B1:   prdata = r_coef_b1;
            mbq_pkg::REG_COEF_B2:   prdata = r_coef_b2;
            mbq_pkg::REG_COEF_A1:   prdata = r_coef_a1;
            mbq_pkg::REG_COEF_A2:   prdata = r_coef_a2;
            mbq_pkg::REG_FRAC_BITS: prdata = 32'(r_frac_bits);
            default:                prdata = '0;
        endcase
    end

    // pipeline control
    logic          r_out_valid;
    mbq_pkg::t_out_word r_out_word;
    logic          w_adv;
    logic          w_hazard;
    logic          w_accept;
    logic [CW-1:0] w_ch;

    logic          r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [CW-1:0] r_s1_ch, r_s2_ch, r_s3_ch, r_s4_ch;

    assign w_adv = !r_out_valid || o_out.ready;
    assign w_ch  = (NUM_CHANNELS > 1) ? CW'(i_in.data.channel) : '0;

    // a channel still in flight has not yet written its history back
    assign w_hazard = (r_s1_vld && (r_s1_ch == w_ch)) ||
                      (r_s2_vld && (r_s2_ch == w_ch)) ||
                      (r_s3_vld && (r_s3_ch == w_ch)) ||
                      (r_s4_vld && (r_s4_ch == w_ch));

    assign i_in.ready = w_adv && !w_hazard;
    assign w_accept   = i_in.valid && i_in.ready;

    // history memory
    logic [mbq_pkg::HIST_W-1:0] w_rdata;
    mbq_pkg::t_hist             n_hist;
    logic                       w_hist_we;
    logic                       r_hist_vld [NUM_CHANNELS];

    mbq_ram #(
        .WIDTH (mbq_pkg::HIST_W),
        .DEPTH (NUM_CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (r_s4_ch),
        .i_wdata (n_hist),
        .i_re    (w_accept),
        .i_raddr (w_ch),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_hist_vld[i] <= 1'b0;
            end
        end else if (w_hist_we) begin
            r_hist_vld[r_s4_ch] <= 1'b1;
        end
    end

    // stage payloads
    logic signed [mbq_pkg::DATA_W-1:0] r_s1_x;
    logic signed [mbq_pkg::DATA_W-1:0] r_s2_x, r_s2_x1, r_s2_y1;
    logic signed [mbq_pkg::DATA_W-1:0] r_s3_x, r_s3_x1, r_s3_y1;
    logic signed [mbq_pkg::DATA_W-1:0] r_s4_x, r_s4_x1, r_s4_y1;
    logic signed [mbq_pkg::ACC_W-1:0]  r_s2_p [5];
    logic signed [mbq_pkg::ACC_W-1:0]  r_s3_sb, r_s3_sa;
    logic signed [mbq_pkg::ACC_W-1:0]  r_s4_acc;
    mbq_pkg::t_hist                    w_hist;
    logic signed [mbq_pkg::ACC_W-1:0]  w_sh;
    mbq_pkg::t_out_word                n_out_word;

    // entry never written since reset reads as zero
    assign w_hist = r_hist_vld[r_s1_ch] ? mbq_pkg::t_hist'(w_rdata) : '0;

    assign w_sh = r_s4_acc >>> r_frac_bits;

    always_comb begin
        n_out_word.sample_out = w_sh[mbq_pkg::DATA_W-1:0];
        n_out_word.overflow   = !((&w_sh[mbq_pkg::ACC_W-1:mbq_pkg::DATA_W-1]) ||
                                  (~|w_sh[mbq_pkg::ACC_W-1:mbq_pkg::DATA_W-1]));
        n_hist.x1 = r_s4_x;
        n_hist.x2 = r_s4_x1;
        n_hist.y1 = w_sh[mbq_pkg::DATA_W-1:0];
        n_hist.y2 = r_s4_y1;
    end

    assign w_hist_we = w_adv && r_s4_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_s4_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld    <= w_accept;
            r_s2_vld    <= r_s1_vld;
            r_s3_vld    <= r_s2_vld;
            r_s4_vld    <= r_s3_vld;
            r_out_valid <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ch <= w_ch;
            r_s1_x  <= i_in.data.sample_in;

            r_s2_ch   <= r_s1_ch;
            r_s2_x    <= r_s1_x;
            r_s2_x1   <= w_hist.x1;
            r_s2_y1   <= w_hist.y1;
            r_s2_p[0] <= mbq_pkg::mul32(r_coef_b0, r_s1_x);
            r_s2_p[1] <= mbq_pkg::mul32(r_coef_b1, w_hist.x1);
            r_s2_p[2] <= mbq_pkg::mul32(r_coef_b2, w_hist.x2);
            r_s2_p[3] <= mbq_pkg::mul32(r_coef_a1, w_hist.y1);
            r_s2_p[4] <= mbq_pkg::mul32(r_coef_a2, w_hist.y2);

            r_s3_ch <= r_s2_ch;
            r_s3_x  <= r_s2_x;
            r_s3_x1 <= r_s2_x1;
            r_s3_y1 <= r_s2_y1;
            r_s3_sb <= r_s2_p[0] + r_s2_p[1] + r_s2_p[2];
            r_s3_sa <= r_s2_p[3] + r_s2_p[4];

            r_s4_ch  <= r_s3_ch;
            r_s4_x   <= r_s3_x;
            r_s4_x1  <= r_s3_x1;
            r_s4_y1  <= r_s3_y1;
            r_s4_acc <= r_s3_sb - r_s3_sa;

            r_out_word <= n_out_word;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_word;

endmodule

FILE: rtl/mbq_ram.sv
// mbq_ram: generic single-write, single-read synchronous ram
// read data registered on read enable; no dependencies
module mbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
